>>> rtl/core/fchd_pkg.sv
// ----------------------------------------------------------------------------
// fchd_pkg
// Shared widths, codes and structs of the foot contact hysteresis detector.
// ----------------------------------------------------------------------------
package fchd_pkg;

  localparam int FOOT_COUNT_DEF = 4;
  localparam int POS_W          = 24;
  localparam int SPEED_W        = 49;
  localparam int CNT_W          = 8;
  localparam int FOOT_W         = 2;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = SPEED_W;

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEIGHT_TH   = 2'd0,
    REG_SPEED_TH    = 2'd1,
    REG_EXIT_FRAMES = 2'd2,
    REG_RELEASE_H   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [POS_W-1:0]   height_threshold;
    logic [SPEED_W-1:0] speed_threshold_sq;
    logic [CNT_W-1:0]   exit_frames;
    logic [POS_W-1:0]   release_height;
  } cfg_t;

  // Motion and height summary handed from the position stage to the lock stage
  typedef struct packed {
    logic             clear;
    logic             update;
    logic             prev_ok;
    logic             h_below;
    logic             h_above;
    logic [POS_W-1:0] mag_x;
    logic [POS_W-1:0] mag_z;
  } motion_t;

  typedef struct packed {
    logic             lock;
    logic [CNT_W-1:0] count;
  } lock_entry_t;

endpackage

>>> rtl/core/fchd_pos_stage.sv
// ----------------------------------------------------------------------------
// fchd_pos_stage
// First stage: previous X/Z position memory, read at request accept,
// written back when the request moves on; forms per-axis motion magnitudes.
// ----------------------------------------------------------------------------
module fchd_pos_stage #(
  parameter int FOOT_COUNT = fchd_pkg::FOOT_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              load,
  input  logic                              advance,
  input  logic                              clear_in,
  input  logic [fchd_pkg::FOOT_W-1:0]       foot_index,
  input  logic signed [fchd_pkg::POS_W-1:0] pos_x,
  input  logic signed [fchd_pkg::POS_W-1:0] pos_height,
  input  logic signed [fchd_pkg::POS_W-1:0] pos_z,
  input  fchd_pkg::cfg_t                    cfg,
  output fchd_pkg::motion_t                 motion,
  output logic [((FOOT_COUNT > 1) ? $clog2(FOOT_COUNT) : 1)-1:0] idx
);
  import fchd_pkg::*;

  localparam int FW = (FOOT_COUNT > 1) ? $clog2(FOOT_COUNT) : 1;
  localparam int XZ_W = 2 * POS_W;

  logic [FW-1:0]     in_idx;
  logic              in_range;
  logic              s1_clear;
  logic              s1_update;
  logic [FW-1:0]     s1_idx;
  logic [POS_W-1:0]  s1_x;
  logic [POS_W-1:0]  s1_z;
  logic [POS_W-1:0]  s1_h;
  logic [XZ_W-1:0]   pos_mem [FOOT_COUNT];
  logic [XZ_W-1:0]   pos_rd;
  logic              fwd_hit;
  logic [XZ_W-1:0]   fwd_data;
  logic [FOOT_COUNT-1:0] pos_valid;
  logic              wr_en;
  logic [XZ_W-1:0]   prev_xz;

  function automatic logic [POS_W-1:0] abs_diff(logic [POS_W-1:0] a, logic [POS_W-1:0] b);
    logic [POS_W:0] d;
    logic [POS_W:0] neg;
    d   = {a[POS_W-1], a} - {b[POS_W-1], b};
    neg = -d;
    return d[POS_W] ? neg[POS_W-1:0] : d[POS_W-1:0];
  endfunction

  assign in_idx   = FW'(foot_index);
  assign in_range = ({5'd0, foot_index} < 7'(FOOT_COUNT));
  assign wr_en    = advance && s1_update;

  // Capture request and read the previous position
  always_ff @(posedge clk) begin
    if (load) begin
      s1_clear  <= clear_in;
      s1_update <= !clear_in && in_range;
      s1_idx    <= in_idx;
      s1_x      <= pos_x;
      s1_z      <= pos_z;
      s1_h      <= pos_height;
      pos_rd    <= pos_mem[in_idx];
      // Forward the entry written at this same edge
      fwd_hit   <= wr_en && (s1_idx == in_idx);
      fwd_data  <= {s1_x, s1_z};
    end
    if (wr_en) begin
      pos_mem[s1_idx] <= {s1_x, s1_z};
    end
  end

  // Track which entries hold a position since the last clear
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_valid <= '0;
    end else if (advance && s1_clear) begin
      pos_valid <= '0;
    end else if (wr_en) begin
      pos_valid[s1_idx] <= 1'b1;
    end
  end

  // Form motion magnitudes and height tests
  always_comb begin
    prev_xz         = fwd_hit ? fwd_data : pos_rd;
    motion.clear    = s1_clear;
    motion.update   = s1_update;
    motion.prev_ok  = s1_update && pos_valid[s1_idx];
    motion.h_below  = $signed(s1_h) < $signed(cfg.height_threshold);
    motion.h_above  = $signed(s1_h) > $signed(cfg.release_height);
    motion.mag_x    = abs_diff(s1_x, prev_xz[XZ_W-1:POS_W]);
    motion.mag_z    = abs_diff(s1_z, prev_xz[POS_W-1:0]);
  end

  assign idx = s1_idx;

endmodule

>>> rtl/core/fchd_lock_stage.sv
// ----------------------------------------------------------------------------
// fchd_lock_stage
// Second stage: lock flag and violation counter memory, squared speed test
// and hysteresis update, written back when the request moves on.
// ----------------------------------------------------------------------------
module fchd_lock_stage #(
  parameter int FOOT_COUNT = fchd_pkg::FOOT_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              advance,
  input  fchd_pkg::motion_t motion_in,
  input  logic [((FOOT_COUNT > 1) ? $clog2(FOOT_COUNT) : 1)-1:0] idx_in,
  input  fchd_pkg::cfg_t    cfg,
  output logic              lock_result
);
  import fchd_pkg::*;

  localparam int FW = (FOOT_COUNT > 1) ? $clog2(FOOT_COUNT) : 1;
  localparam int SQ_W = 2 * POS_W;

  motion_t           s2_m;
  logic [FW-1:0]     s2_idx;
  lock_entry_t       lock_mem [FOOT_COUNT];
  lock_entry_t       lock_rd;
  logic              fwd_hit;
  lock_entry_t       fwd_data;
  logic [FOOT_COUNT-1:0] lock_valid;
  logic              wr_en;
  logic [SQ_W-1:0]   sq_x;
  logic [SQ_W-1:0]   sq_z;
  logic [SPEED_W-1:0] speed_sq;
  logic              raw;
  lock_entry_t       cur;
  lock_entry_t       entry_next;
  logic [CNT_W-1:0]  cnt_inc;

  assign wr_en = advance && s2_m.update;

  // Capture request and read the lock entry
  always_ff @(posedge clk) begin
    if (load) begin
      s2_m     <= motion_in;
      s2_idx   <= idx_in;
      lock_rd  <= lock_mem[idx_in];
      fwd_hit  <= wr_en && (s2_idx == idx_in);
      fwd_data <= entry_next;
    end
    if (wr_en) begin
      lock_mem[s2_idx] <= entry_next;
    end
  end

  // Entries not written since the last clear read as unlocked, count zero
  always_ff @(posedge clk) begin
    if (rst) begin
      lock_valid <= '0;
    end else if (advance && s2_m.clear) begin
      lock_valid <= '0;
    end else if (wr_en) begin
      lock_valid[s2_idx] <= 1'b1;
    end
  end

  // Squared horizontal speed and raw contact
  always_comb begin
    sq_x     = s2_m.mag_x * s2_m.mag_x;
    sq_z     = s2_m.mag_z * s2_m.mag_z;
    speed_sq = s2_m.prev_ok ? ({1'b0, sq_x} + {1'b0, sq_z}) : '0;
    raw      = s2_m.h_below && (speed_sq < cfg.speed_threshold_sq);
  end

  // Hysteresis update
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_data;
    end else if (lock_valid[s2_idx]) begin
      cur = lock_rd;
    end else begin
      cur = '0;
    end
    cnt_inc    = cur.count + CNT_W'(1);
    entry_next = cur;
    if (!cur.lock) begin
      if (raw) begin
        entry_next.lock  = 1'b1;
        entry_next.count = '0;
      end
    end else if (s2_m.h_above) begin
      entry_next = '0;
    end else if (!raw) begin
      if (cnt_inc >= cfg.exit_frames) begin
        entry_next = '0;
      end else begin
        entry_next.count = cnt_inc;
      end
    end else begin
      entry_next.count = '0;
    end
    lock_result = s2_m.update ? entry_next.lock : 1'b0;
  end

endmodule

>>> rtl/core/foot_contact_hysteresis_detector_core.sv
// ----------------------------------------------------------------------------
// foot_contact_hysteresis_detector_core
// Per-foot contact lock with hysteresis: position stage, lock stage and a
// result register, one request per cycle while results are taken.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | opcode, foot_index, pos_x, pos_height, pos_z
//  out     | out_valid / out_ready| locked
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  One request per cycle sustained while out_ready holds; out_valid rises
//  after the request has passed the position stage, then the lock stage into
//  the result register.
//  Each state memory is read once and written once per cycle; a write to the
//  entry read at the same edge is forwarded.
//  Reset clears per-foot valid bits at once; no clearing pass is needed.
//  A stalled result holds the pipeline; in_ready drops only when all three
//  stages are full. cfg_ready is always high.
// ----------------------------------------------------------------------------
module foot_contact_hysteresis_detector_core #(
  parameter int FOOT_COUNT = fchd_pkg::FOOT_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                opcode,
  input  logic [fchd_pkg::FOOT_W-1:0]         foot_index,
  input  logic signed [fchd_pkg::POS_W-1:0]   pos_x,
  input  logic signed [fchd_pkg::POS_W-1:0]   pos_height,
  input  logic signed [fchd_pkg::POS_W-1:0]   pos_z,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                locked,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fchd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fchd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fchd_pkg::*;

  localparam int FW = (FOOT_COUNT > 1) ? $clog2(FOOT_COUNT) : 1;

  cfg_t          cfg;
  logic          s1_valid;
  logic          s2_valid;
  logic          out_free;
  logic          s2_free;
  logic          s1_adv;
  logic          s2_adv;
  logic          in_accept;
  motion_t       motion;
  logic [FW-1:0] s1_idx;
  logic          lock_result;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height_threshold   <= POS_W'(1280);
      cfg.speed_threshold_sq <= SPEED_W'(65536);
      cfg.exit_frames        <= CNT_W'(3);
      cfg.release_height     <= POS_W'(2560);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEIGHT_TH:   cfg.height_threshold   <= cfg_data[POS_W-1:0];
        REG_SPEED_TH:    cfg.speed_threshold_sq <= cfg_data[SPEED_W-1:0];
        REG_EXIT_FRAMES: cfg.exit_frames        <= cfg_data[CNT_W-1:0];
        REG_RELEASE_H:   cfg.release_height     <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control
  assign out_free  = !out_valid || out_ready;
  assign s2_free   = !s2_valid || out_free;
  assign s2_adv    = s2_valid && out_free;
  assign s1_adv    = s1_valid && s2_free;
  assign in_ready  = !s1_valid || s2_free;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid <= 1'b1;
      end else if (s2_adv) begin
        s2_valid <= 1'b0;
      end
      if (s2_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      locked <= lock_result;
    end
  end

  fchd_pos_stage #(
    .FOOT_COUNT(FOOT_COUNT)
  ) u_pos (
    .clk        (clk),
    .rst        (rst),
    .load       (in_accept),
    .advance    (s1_adv),
    .clear_in   (opcode == OP_CLEAR),
    .foot_index (foot_index),
    .pos_x      (pos_x),
    .pos_height (pos_height),
    .pos_z      (pos_z),
    .cfg        (cfg),
    .motion     (motion),
    .idx        (s1_idx)
  );

  fchd_lock_stage #(
    .FOOT_COUNT(FOOT_COUNT)
  ) u_lock (
    .clk         (clk),
    .rst         (rst),
    .load        (s1_adv),
    .advance     (s2_adv),
    .motion_in   (motion),
    .idx_in      (s1_idx),
    .cfg         (cfg),
    .lock_result (lock_result)
  );

endmodule

>>> rtl/core/fchd_checker.sv
// ----------------------------------------------------------------------------
// fchd_checker
// Port-level checks of the foot contact detector: pipeline occupancy,
// result hold under stall and reset behavior.
// ----------------------------------------------------------------------------
module fchd_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic locked
);

  logic [2:0] pending;

  // Count requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(in_valid && in_ready) - 3'(out_valid && out_ready);
    end
  end

  // No more than three requests in flight
  assert property (@(posedge clk) disable iff (rst) pending <= 3'd3)
    else $error("more requests in flight than pipeline stages");

  // A result is shown only for an accepted request
  assert property (@(posedge clk) disable iff (rst) out_valid |-> pending != 3'd0)
    else $error("result shown without an outstanding request");

  // A stalled result holds its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(locked))
    else $error("stalled result dropped or changed");

  // Reset empties the output
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind foot_contact_hysteresis_detector_core fchd_checker u_fchd_checker (.*);
